/* hdl/diag_security_access_seed_key_macros.svh */
`ifndef DIAG_SECURITY_ACCESS_SEED_KEY_MACROS_SVH
`define DIAG_SECURITY_ACCESS_SEED_KEY_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DSASK_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dsask: implication check failed");

// next-cycle implication, disabled while in reset
`define DSASK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dsask: next-cycle check failed");

`endif

/* hdl/dsask_pkg.sv */
package dsask_pkg;

	typedef enum logic [1:0] {
		OP_REQUEST = 2'd0,
		OP_TICK    = 2'd1,
		OP_SESSION = 2'd2,
		OP_STOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SESS_DEFAULT = 2'd0,
		SESS_PRG     = 2'd1,
		SESS_EXT     = 2'd2,
		SESS_OTHER   = 2'd3
	} session_t;

	typedef enum logic [1:0] {
		KIND_SEED = 2'd0,
		KIND_KEY  = 2'd1,
		KIND_NEG  = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		NEG_NONE        = 4'd0,
		NEG_SVC         = 4'd1,
		NEG_CONDITIONS  = 4'd2,
		NEG_SUBFN       = 4'd3,
		NEG_SUBFN_SESS  = 4'd4,
		NEG_LENGTH      = 4'd5,
		NEG_ATTEMPTS    = 4'd6,
		NEG_DELAY       = 4'd7,
		NEG_SEQUENCE    = 4'd8,
		NEG_INVALID_KEY = 4'd9
	} neg_t;

	typedef enum logic [1:0] {
		CFG_SEED_START_HIGH = 2'd0,
		CFG_SEED_START_LOW  = 2'd1,
		CFG_MAX_ATTEMPTS    = 2'd2,
		CFG_DELAY_TICKS     = 2'd3
	} cfg_index_t;

	localparam logic [31:0] KEY_ADD        = 32'h5A5A_AA55;
	localparam logic [31:0] SEED_BYTE_MASK = 32'hFEFE_FEFE;
	localparam logic [3:0]  MAX_ATT_RST    = 4'd3;
	localparam logic [15:0] DELAY_RST      = 16'd10000;
	localparam logic [3:0]  FAIL_SAT       = 4'hF;
	localparam logic [2:0]  LOCK_RST       = 3'b001;
	localparam logic [7:0]  LEN_MIN        = 8'd2;
	localparam logic [7:0]  LEN_SEED_REQ   = 8'd2;
	localparam logic [7:0]  LEN_KEY_REQ    = 8'd10;
	localparam logic [3:0]  RLEN_SEED      = 4'd10;
	localparam logic [3:0]  RLEN_KEY       = 4'd2;
	localparam logic [6:0]  LEVEL_PRG      = 7'd4;
	localparam logic [6:0]  LEVEL_EXT      = 7'd2;

	// lock bit 2: programming, bit 1: extended; other sessions are always open
	function automatic logic sess_unlocked(logic [1:0] s, logic [2:0] lock);
		logic r;
		r = 1'b1;
		if (s == SESS_PRG)
			r = lock[2];
		else if (s == SESS_EXT)
			r = lock[1];
		return r;
	endfunction

endpackage

/* hdl/diag_security_access_seed_key.sv */
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// input    | in_valid / in_ready  | op, session, sub_function, request_length,
//          |                      | physical_address, battery_ok, key_high/low
// result   | out_valid / out_ready| response_kind .. delay_running
// config   | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready is high; each one gives exactly one result.
// A transaction passes the input register, then one pass of checks, a 32-bit
// add and compare per seed word, and the state update into the result register.
// in_ready drops only while the input stage holds a transaction and the result
// register is full and not being taken.
// arst_n resets the security state and the config registers to their defaults and clears both valid flags.
`include "diag_security_access_seed_key_macros.svh"

module diag_security_access_seed_key import dsask_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [1:0]  session,
	input  logic [7:0]  sub_function,
	input  logic [7:0]  request_length,
	input  logic        physical_address,
	input  logic        battery_ok,
	input  logic [31:0] key_high,
	input  logic [31:0] key_low,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  response_kind,
	output logic [3:0]  neg_code,
	output logic [3:0]  response_length,
	output logic [6:0]  response_level,
	output logic [31:0] seed_out_high,
	output logic [31:0] seed_out_low,
	output logic        unlocked_now,
	output logic [3:0]  fail_count_now,
	output logic        delay_running,

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// configuration
	logic [31:0] seed_start_high_q, seed_start_low_q;
	logic [3:0]  max_attempts_q;
	logic [15:0] delay_ticks_q;

	// security state
	logic [2:0]  lock_q, lock_d;
	logic        seed_sent_q, seed_sent_d;
	logic [3:0]  fail_count_q, fail_count_d;
	logic [31:0] seed_high_q, seed_high_d;
	logic [31:0] seed_low_q, seed_low_d;
	logic        delay_active_q, delay_active_d;
	logic [15:0] delay_left_q, delay_left_d;

	// input stage
	logic        valid_s1;
	op_t         op_s1;
	logic [1:0]  session_s1;
	logic [7:0]  sub_function_s1;
	logic [7:0]  request_length_s1;
	logic        physical_address_s1;
	logic        battery_ok_s1;
	logic [31:0] key_high_s1, key_low_s1;

	// result stage
	logic        valid_s2;
	kind_t       kind_s2, kind_d;
	neg_t        neg_s2, neg_d;
	logic [3:0]  rlen_s2, rlen_d;
	logic [6:0]  rlev_s2, rlev_d;
	logic [31:0] seed_out_high_s2, seed_out_high_d;
	logic [31:0] seed_out_low_s2, seed_out_low_d;
	logic        unlocked_s2, unlocked_d;
	logic [3:0]  fail_count_s2;
	logic        delay_running_s2;

	logic advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_start_high_q <= '0;
			seed_start_low_q  <= '0;
			max_attempts_q    <= MAX_ATT_RST;
			delay_ticks_q     <= DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEED_START_HIGH: seed_start_high_q <= cfg_data;
				CFG_SEED_START_LOW:  seed_start_low_q  <= cfg_data;
				CFG_MAX_ATTEMPTS:    max_attempts_q    <= cfg_data[3:0];
				CFG_DELAY_TICKS:     delay_ticks_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1               <= op_t'(op);
			session_s1          <= session;
			sub_function_s1     <= sub_function;
			request_length_s1   <= request_length;
			physical_address_s1 <= physical_address;
			battery_ok_s1       <= battery_ok;
			key_high_s1         <= key_high;
			key_low_s1          <= key_low;
		end
	end

	always_comb begin
		logic [6:0]  level;
		logic        seed_req;
		logic        guarded;
		logic        level_bad;
		logic        unlocked_cur;
		neg_t        reject;
		neg_t        chk;
		logic [31:0] exp_high, exp_low;
		logic [3:0]  fc_inc;
		logic [15:0] left_dec;

		level        = sub_function_s1[6:0];
		seed_req     = sub_function_s1[0];
		guarded      = (session_s1 == SESS_PRG) || (session_s1 == SESS_EXT);
		unlocked_cur = sess_unlocked(session_s1, lock_q);
		level_bad    = ((session_s1 == SESS_PRG) && (level != 7'd3) && (level != 7'd4)) ||
			((session_s1 == SESS_EXT) && (level != 7'd1) && (level != 7'd2));

		if (request_length_s1 < LEN_MIN)
			reject = NEG_LENGTH;
		else if ((level < 7'd1) || (level > 7'd4))
			reject = NEG_SUBFN;
		else
			reject = NEG_SUBFN_SESS;

		// checks in priority order
		if (!physical_address_s1)
			chk = NEG_SVC;
		else if (!battery_ok_s1)
			chk = NEG_CONDITIONS;
		else if (level_bad)
			chk = reject;
		else if (guarded && (request_length_s1 != (seed_req ? LEN_SEED_REQ : LEN_KEY_REQ)))
			chk = NEG_LENGTH;
		else if (guarded && !seed_sent_q && delay_active_q)
			chk = seed_req ? NEG_DELAY : NEG_ATTEMPTS;
		else if (!seed_sent_q && !seed_req)
			chk = unlocked_cur ? NEG_SEQUENCE : NEG_CONDITIONS;
		else
			chk = NEG_NONE;

		exp_high = ~seed_high_q + KEY_ADD;
		exp_low  = ~seed_low_q + KEY_ADD;
		fc_inc   = (fail_count_q != FAIL_SAT) ? fail_count_q + 4'd1 : fail_count_q;
		left_dec = (delay_left_q != 16'd0) ? delay_left_q - 16'd1 : delay_left_q;

		lock_d          = lock_q;
		seed_sent_d     = seed_sent_q;
		fail_count_d    = fail_count_q;
		seed_high_d     = seed_high_q;
		seed_low_d      = seed_low_q;
		delay_active_d  = delay_active_q;
		delay_left_d    = delay_left_q;
		kind_d          = KIND_NONE;
		neg_d           = NEG_NONE;
		rlen_d          = '0;
		rlev_d          = '0;
		seed_out_high_d = '0;
		seed_out_low_d  = '0;

		case (op_s1)
			OP_REQUEST: begin
				if (chk != NEG_NONE) begin
					seed_sent_d = 1'b0;
					kind_d      = KIND_NEG;
					neg_d       = chk;
				end else if (seed_req) begin
					kind_d = KIND_SEED;
					rlen_d = RLEN_SEED;
					if (unlocked_cur) begin
						seed_sent_d = 1'b0;
					end else begin
						// double each upper seed byte mod 256
						seed_sent_d     = 1'b1;
						seed_high_d     = {seed_high_q[30:0], 1'b0} & SEED_BYTE_MASK;
						seed_out_high_d = seed_high_d;
						seed_out_low_d  = seed_low_q;
					end
				end else begin
					seed_sent_d = 1'b0;
					if ((exp_high == key_high_s1) && (exp_low == key_low_s1)) begin
						fail_count_d = '0;
						if (session_s1 == SESS_PRG) begin
							lock_d[2] = 1'b1;
							kind_d    = KIND_KEY;
							rlen_d    = RLEN_KEY;
							rlev_d    = LEVEL_PRG;
						end else if (session_s1 == SESS_EXT) begin
							lock_d[1] = 1'b1;
							kind_d    = KIND_KEY;
							rlen_d    = RLEN_KEY;
							rlev_d    = LEVEL_EXT;
						end
					end else begin
						kind_d = KIND_NEG;
						if (fc_inc >= max_attempts_q) begin
							fail_count_d = max_attempts_q;
							// one-shot: leave a running delay alone
							if (!delay_active_q) begin
								delay_active_d = 1'b1;
								delay_left_d   = delay_ticks_q;
							end
							neg_d = NEG_ATTEMPTS;
						end else begin
							fail_count_d = fc_inc;
							neg_d        = NEG_INVALID_KEY;
						end
					end
				end
			end
			OP_TICK: begin
				if (delay_active_q) begin
					delay_left_d = left_dec;
					if (left_dec == 16'd0) begin
						delay_active_d = 1'b0;
						if (fail_count_q != 4'd0)
							fail_count_d = fail_count_q - 4'd1;
					end
				end
			end
			OP_SESSION: begin
				seed_sent_d  = 1'b0;
				fail_count_d = '0;
				lock_d       = LOCK_RST;
				seed_high_d  = seed_start_high_q;
				seed_low_d   = seed_start_low_q;
			end
			OP_STOP: begin
				delay_active_d = 1'b0;
				delay_left_d   = '0;
				lock_d         = LOCK_RST;
			end
			default: ;
		endcase

		unlocked_d = sess_unlocked(session_s1, lock_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q         <= LOCK_RST;
			seed_sent_q    <= 1'b0;
			fail_count_q   <= '0;
			seed_high_q    <= '0;
			seed_low_q     <= '0;
			delay_active_q <= 1'b0;
			delay_left_q   <= '0;
		end else if (advance) begin
			lock_q         <= lock_d;
			seed_sent_q    <= seed_sent_d;
			fail_count_q   <= fail_count_d;
			seed_high_q    <= seed_high_d;
			seed_low_q     <= seed_low_d;
			delay_active_q <= delay_active_d;
			delay_left_q   <= delay_left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (out_ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s2          <= kind_d;
			neg_s2           <= neg_d;
			rlen_s2          <= rlen_d;
			rlev_s2          <= rlev_d;
			seed_out_high_s2 <= seed_out_high_d;
			seed_out_low_s2  <= seed_out_low_d;
			unlocked_s2      <= unlocked_d;
			fail_count_s2    <= fail_count_d;
			delay_running_s2 <= delay_active_d;
		end
	end

	assign out_valid       = valid_s2;
	assign response_kind   = kind_s2;
	assign neg_code        = neg_s2;
	assign response_length = rlen_s2;
	assign response_level  = rlev_s2;
	assign seed_out_high   = seed_out_high_s2;
	assign seed_out_low    = seed_out_low_s2;
	assign unlocked_now    = unlocked_s2;
	assign fail_count_now  = fail_count_s2;
	assign delay_running   = delay_running_s2;

	`DSASK_ASSERT_IMPLY(a_key_unlocks, clk, arst_n, valid_s2 && (kind_s2 == KIND_KEY), unlocked_s2)
	`DSASK_ASSERT_IMPLY(a_seed_zero, clk, arst_n, valid_s2 && (kind_s2 != KIND_SEED), (seed_out_high_s2 == 32'd0) && (seed_out_low_s2 == 32'd0))
	`DSASK_ASSERT_IMPLY(a_ready_empty, clk, arst_n, !valid_s2, in_ready)
	`DSASK_ASSERT_NEXT(a_stage_hold, clk, arst_n, valid_s1 && !advance, valid_s1)

endmodule
